// ===== design/osa_pkg.sv =====
// Shared types and constants of the operand stack ALU.
package osa_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int DEPTH_OUT_W  = 7;
    localparam int MIN_OPERANDS = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_SWAP = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_NOP  = 3'd3,
        CMD_SUB  = 3'd4,
        CMD_DIV  = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

endpackage

// ===== design/osa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module osa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/osa_div.sv =====
// Bit-serial signed divider, truncating toward zero, one quotient bit per cycle.
module osa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [osa_pkg::DATA_W-1:0]  i_num,
    input  logic [osa_pkg::DATA_W-1:0]  i_den,
    output logic                        o_done,
    output logic [osa_pkg::DATA_W-1:0]  o_quot
);

    import osa_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_div_state;

    t_div_state        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;

    assign rem_shift = {r_rem, r_quo[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        // Work on magnitudes; the sign is restored at the end.
                        r_rem   <= '0;
                        r_quo   <= i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
                        r_den   <= i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
                        r_neg   <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (!diff[DATA_W]) begin
                        r_rem <= diff[DATA_W-1:0];
                        r_quo <= {r_quo[DATA_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_shift[DATA_W-1:0];
                        r_quo <= {r_quo[DATA_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_FIX);
    assign o_quot = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

// ===== design/operand_stack_alu.sv =====
// Operand stack of a bytecode interpreter with an integer ALU on its top two entries.
//
// An item is taken when start is high and busy is low; every item gives exactly one
// result, shown for a single cycle with o_valid high, which the receiver must take.
// The stack lives in a RAM with one write and one registered read port; the top entry
// is also kept in a register so that only the entry below it has to be read. Push, nop
// and every command that ends in an error give their result in the cycle after start and
// leave busy low, so such items may follow in every cycle. Add and sub pass S_EXEC, swap
// S_EXEC and S_SWAP2 (two RAM writes), and div S_EXEC, then S_DIV while the bit-serial
// divider makes one quotient bit per cycle. The stack needs no clearing after reset.
module operand_stack_alu #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [osa_pkg::CMD_W-1:0]         i_command,
    input  logic signed [osa_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    output logic [osa_pkg::STATUS_W-1:0]      o_status,
    output logic signed [osa_pkg::DATA_W-1:0] o_top_value,
    output logic [osa_pkg::DEPTH_OUT_W-1:0]   o_depth
);

    import osa_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP2,
        S_DIV
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_top;
    logic              r_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_top_out;
    logic [CW-1:0]     r_depth_out;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] alu_res;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    t_cmd              in_cmd;

    assign in_cmd   = t_cmd'(i_command);
    assign count_m1 = r_count - CW'(1);
    assign count_m2 = r_count - CW'(2);

    // The entry below the top is always being read; it is valid in the cycle after.
    assign rd_addr = count_m2[AW-1:0];

    // rd_data is b, r_top is a.
    assign alu_res   = (r_cmd == CMD_SUB) ? (rd_data - r_top) : (rd_data + r_top);
    assign div_start = (r_state == S_EXEC) && (r_cmd == CMD_DIV);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_m2[AW-1:0];
        wr_data = alu_res;
        case (r_state)
            S_IDLE: begin
                wr_en   = start && (in_cmd == CMD_PUSH) && (r_count != CW'(STACK_DEPTH));
                wr_addr = r_count[AW-1:0];
                wr_data = i_push_value;
            end
            S_EXEC: begin
                wr_en   = (r_cmd != CMD_DIV);
                wr_data = (r_cmd == CMD_SWAP) ? r_top : alu_res;
            end
            S_SWAP2: begin
                wr_en   = 1'b1;
                wr_addr = count_m1[AW-1:0];
                wr_data = r_top;
            end
            S_DIV: begin
                wr_en   = div_done;
                wr_data = div_quot;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    osa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    osa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (rd_data),
        .i_den   (r_top),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_top       <= '0;
            r_valid     <= 1'b0;
            r_status    <= ST_OK;
            r_top_out   <= '0;
            r_depth_out <= '0;
            r_cmd       <= CMD_NOP;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd       <= in_cmd;
                        r_status    <= ST_OK;
                        r_top_out   <= r_top;
                        r_depth_out <= r_count;
                        r_valid     <= 1'b1;
                        case (in_cmd)
                            CMD_PUSH: begin
                                if (r_count == CW'(STACK_DEPTH)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_top       <= i_push_value;
                                    r_count     <= r_count + CW'(1);
                                    r_top_out   <= i_push_value;
                                    r_depth_out <= r_count + CW'(1);
                                end
                            end
                            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV: begin
                                if (r_count < CW'(MIN_OPERANDS)) begin
                                    r_status <= ST_SHORT;
                                end else if (in_cmd == CMD_DIV && r_top == '0) begin
                                    r_status <= ST_DIVZERO;
                                end else begin
                                    r_valid <= 1'b0;
                                    r_state <= S_EXEC;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    case (r_cmd)
                        CMD_SWAP: begin
                            // Old top now sits below; the old second entry becomes top.
                            r_top   <= rd_data;
                            r_state <= S_SWAP2;
                        end
                        CMD_DIV: begin
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_top       <= alu_res;
                            r_count     <= count_m1;
                            r_top_out   <= alu_res;
                            r_depth_out <= count_m1;
                            r_valid     <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    endcase
                end
                S_SWAP2: begin
                    r_top_out   <= r_top;
                    r_depth_out <= r_count;
                    r_valid     <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_top       <= div_quot;
                        r_count     <= count_m1;
                        r_top_out   <= div_quot;
                        r_depth_out <= count_m1;
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_top_value = r_top_out;
    assign o_depth     = DEPTH_OUT_W'(r_depth_out);

endmodule

// ===== tb/operand_stack_alu_tb.sv =====
// Self-checking testbench for the operand stack ALU: directed table, then random command streams.
module operand_stack_alu_tb;
    import osa_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int IDLE_PCT     = 31;

    // Command codes outside the enum, which the block must treat as nop.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        t_status                  status;
        logic [DATA_W-1:0]        top;
        logic [DEPTH_OUT_W-1:0]   depth;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        logic [6:0]        reps;
        logic              has_exp;
        t_result           exp;
    } t_row;

    localparam int N_ROWS = 24;

    // Rows with has_exp set carry a result that is plain from the command; the rest are
    // left to the stack model.
    t_row directed_rows [0:N_ROWS-1] = '{
        '{CMD_NOP,    32'h0000_0000, 7'd1,  1'b1, '{ST_OK,      32'h0000_0000, 7'd0}},
        '{CMD_SPARE6, 32'hFFFF_FFFF, 7'd1,  1'b1, '{ST_OK,      32'h0000_0000, 7'd0}},
        '{CMD_SPARE7, 32'h1234_5678, 7'd1,  1'b1, '{ST_OK,      32'h0000_0000, 7'd0}},
        '{CMD_SWAP,   32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_ADD,    32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_SUB,    32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_DIV,    32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h0000_0000, 7'd0}},
        '{CMD_PUSH,   32'h8000_0000, 7'd1,  1'b1, '{ST_OK,      32'h8000_0000, 7'd1}},
        '{CMD_SWAP,   32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h8000_0000, 7'd1}},
        '{CMD_DIV,    32'h0000_0000, 7'd1,  1'b1, '{ST_SHORT,   32'h8000_0000, 7'd1}},
        '{CMD_PUSH,   32'h0000_0000, 7'd1,  1'b1, '{ST_OK,      32'h0000_0000, 7'd2}},
        '{CMD_DIV,    32'h0000_0000, 7'd1,  1'b1, '{ST_DIVZERO, 32'h0000_0000, 7'd2}},
        '{CMD_SUB,    32'h0000_0000, 7'd1,  1'b0, '0},
        '{CMD_PUSH,   32'hFFFF_FFFF, 7'd1,  1'b1, '{ST_OK,      32'hFFFF_FFFF, 7'd2}},
        '{CMD_DIV,    32'h0000_0000, 7'd1,  1'b1, '{ST_OK,      32'h8000_0000, 7'd1}},
        '{CMD_PUSH,   32'h7FFF_FFFF, 7'd1,  1'b1, '{ST_OK,      32'h7FFF_FFFF, 7'd2}},
        '{CMD_ADD,    32'h0000_0000, 7'd1,  1'b0, '0},
        '{CMD_PUSH,   32'h0000_0007, 7'd1,  1'b0, '0},
        '{CMD_SWAP,   32'h0000_0000, 7'd1,  1'b0, '0},
        '{CMD_SUB,    32'h0000_0000, 7'd1,  1'b0, '0},
        '{CMD_PUSH,   32'hFFFF_FFFD, 7'd1,  1'b0, '0},
        '{CMD_DIV,    32'h0000_0000, 7'd1,  1'b0, '0},
        // One entry is left, so 63 pushes fill the stack and the next one must bounce.
        '{CMD_PUSH,   32'h5555_5555, 7'd63, 1'b0, '0},
        '{CMD_PUSH,   32'hAAAA_AAAA, 7'd1,  1'b1, '{ST_FULL,    32'h5555_5555, 7'd64}}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          i_command;
    logic signed [DATA_W-1:0]  i_push_value;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic signed [DATA_W-1:0]  o_top_value;
    logic [DEPTH_OUT_W-1:0]    o_depth;

    // Typed-in expectation travelling with the item that is currently offered.
    logic                      fixed_valid;
    t_result                   fixed_exp;
    logic                      no_idle;

    logic [DATA_W-1:0]         stack_model [0:STACK_DEPTH-1];
    int                        stack_depth;
    t_result                   pending_results [$];
    t_result                   oldest;
    t_result                   predicted;

    int                        fail_count;
    int                        items_accepted;
    int                        results_checked;
    int                        status_seen [0:3];
    int                        cycle_count;

    operand_stack_alu #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_push_value(i_push_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_depth     (o_depth)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Applies one command to the model stack and returns what the block should report.
    function automatic t_result stack_step(input logic [CMD_W-1:0] cmd,
                                           input logic [DATA_W-1:0] value);
        t_result           r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quot;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (stack_depth >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_model[stack_depth] = value;
                    stack_depth++;
                end
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV: begin
                if (stack_depth < MIN_OPERANDS) begin
                    r.status = ST_SHORT;
                end else begin
                    a = stack_model[stack_depth-1];
                    b = stack_model[stack_depth-2];
                    if (cmd == CMD_SWAP) begin
                        stack_model[stack_depth-1] = b;
                        stack_model[stack_depth-2] = a;
                    end else if (cmd == CMD_DIV && a == '0) begin
                        r.status = ST_DIVZERO;
                    end else begin
                        if (cmd == CMD_ADD) begin
                            b = b + a;
                        end else if (cmd == CMD_SUB) begin
                            b = b - a;
                        end else begin
                            // Divide magnitudes so that the most negative quotient wraps.
                            mag_a = a[DATA_W-1] ? -a : a;
                            mag_b = b[DATA_W-1] ? -b : b;
                            quot  = mag_b / mag_a;
                            b     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
                        end
                        stack_model[stack_depth-2] = b;
                        stack_depth--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.top   = (stack_depth > 0) ? stack_model[stack_depth-1] : '0;
        r.depth = stack_depth[DEPTH_OUT_W-1:0];
        return r;
    endfunction

    // Offers one item, with a random gap before it unless no_idle is set, and returns at
    // the falling edge after it was taken.
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              input logic has_exp, input t_result exp);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_push_value <= value;
        fixed_valid  <= has_exp;
        fixed_exp    <= exp;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item outstanding: status %0d top %h depth %0d",
                           o_status, o_top_value, o_depth);
                    fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    results_checked++;
                    status_seen[o_status]++;
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, o_status);
                        fail_count++;
                    end
                    if (o_top_value !== oldest.top) begin
                        $error("top_value: expected %h, got %h", oldest.top, o_top_value);
                        fail_count++;
                    end
                    if (o_depth !== oldest.depth) begin
                        $error("depth: expected %0d, got %0d", oldest.depth, o_depth);
                        fail_count++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                predicted = stack_step(i_command, i_push_value);
                pending_results.push_back(fixed_valid ? fixed_exp : predicted);
                items_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int               push_pct;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [DATA_W-1:0] value;

        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_NOP;
        i_push_value    = '0;
        fixed_valid     = 1'b0;
        fixed_exp       = '0;
        no_idle         = 1'b0;
        stack_depth     = 0;
        fail_count      = 0;
        items_accepted  = 0;
        results_checked = 0;
        cycle_count     = 0;
        for (int s = 0; s < 4; s++) status_seen[s] = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                offer_item(directed_rows[r].cmd, directed_rows[r].value,
                           directed_rows[r].has_exp, directed_rows[r].exp);
            end
        end

        // Random streams in phases that lean towards filling, balancing or draining the
        // stack, so that both the full and the nearly empty stack are visited often.
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 75;
                    1:       push_pct = 45;
                    default: push_pct = 15;
                endcase
            end
            no_idle = (n >= 300 && n < 450);
            if ($urandom_range(99) < push_pct) begin
                cmd = CMD_PUSH;
            end else begin
                pick = $urandom_range(11);
                case (pick)
                    0, 1:    cmd = CMD_SWAP;
                    2, 3:    cmd = CMD_ADD;
                    4, 5:    cmd = CMD_SUB;
                    6, 7, 8: cmd = CMD_DIV;
                    9:       cmd = CMD_NOP;
                    10:      cmd = CMD_SPARE6;
                    default: cmd = CMD_SPARE7;
                endcase
            end
            // Small values make zero divisors and exact quotients common.
            case ($urandom_range(9))
                0:       value = '0;
                1:       value = 32'h8000_0000;
                2:       value = 32'h7FFF_FFFF;
                3:       value = 32'hFFFF_FFFF;
                4, 5:    value = $urandom_range(16) - 8;
                default: value = $urandom;
            endcase
            offer_item(cmd, value, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d items taken and %0d results compared.", items_accepted, results_checked);
        $display("Statuses seen: %0d ok, %0d too short, %0d divide by zero, %0d stack full.",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_DIVZERO],
                 status_seen[ST_FULL]);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== operand_stack_alu.f =====
design/osa_pkg.sv
design/osa_ram.sv
design/osa_div.sv
design/operand_stack_alu.sv
tb/operand_stack_alu_tb.sv
